// ===== hw/rtl/bigram_markov_gibberish_scorer_macros.svh =====
// Assertion macros shared by the gibberish scorer RTL.
`ifndef BIGRAM_MARKOV_GIBBERISH_SCORER_MACROS_SVH
`define BIGRAM_MARKOV_GIBBERISH_SCORER_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define BMG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define BMG_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/bmg_pkg.sv =====
// Shared types, constants and helper functions of the gibberish scorer.
package bmg_pkg;

    localparam int ALPHABET_SIZE = 27;
    localparam int IDX_WIDTH     = 5;
    localparam int TABLE_DEPTH   = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int ADDR_WIDTH    = $clog2(TABLE_DEPTH);
    localparam int CHAR_WIDTH    = 8;
    localparam int LOAD_WIDTH    = 16;
    localparam int THR_WIDTH     = 16;
    localparam int SUM_WIDTH     = 40;

    localparam logic signed [THR_WIDTH-1:0] THR_RESET = -16'sd4096;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CHAR = 1'b1;

    // Character codes
    localparam logic [CHAR_WIDTH-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] LOWER_A    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] LOWER_Z    = 8'h7a;
    localparam logic [CHAR_WIDTH-1:0] UPPER_A    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] UPPER_Z    = 8'h5a;

    typedef struct packed {
        logic                 kept;
        logic [IDX_WIDTH-1:0] idx;
    } char_info_t;

    // Control that travels with a character item into the accumulator
    typedef struct packed {
        logic add;
        logic last;
    } s1_ctrl_t;

    // Fold a raw byte to its alphabet index; space takes the top index.
    function automatic char_info_t char_decode(input logic [CHAR_WIDTH-1:0] c);
        char_info_t r;
        r.kept = 1'b0;
        r.idx  = '0;
        if (c >= LOWER_A && c <= LOWER_Z) begin
            r.kept = 1'b1;
            r.idx  = IDX_WIDTH'(c - LOWER_A);
        end else if (c >= UPPER_A && c <= UPPER_Z) begin
            r.kept = 1'b1;
            r.idx  = IDX_WIDTH'(c - UPPER_A);
        end else if (c == SPACE_CHAR) begin
            r.kept = 1'b1;
            r.idx  = IDX_WIDTH'(ALPHABET_SIZE - 1);
        end
        return r;
    endfunction

    // Row-major address of a bigram entry.
    function automatic logic [ADDR_WIDTH-1:0] table_addr(input logic [IDX_WIDTH-1:0] row,
                                                         input logic [IDX_WIDTH-1:0] col);
        return ADDR_WIDTH'(row * ALPHABET_SIZE + col);
    endfunction

endpackage

// ===== hw/rtl/bmg_table.sv =====
// Bigram log probability table: one write port, one registered read port.
module bmg_table #(
    parameter int PROB_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [bmg_pkg::ADDR_WIDTH-1:0] wr_addr,
    input  logic [PROB_WIDTH-1:0]          wr_data,
    input  logic                           rd_en,
    input  logic [bmg_pkg::ADDR_WIDTH-1:0] rd_addr,
    output logic [PROB_WIDTH-1:0]          rd_data
);

    logic [PROB_WIDTH-1:0] mem [bmg_pkg::TABLE_DEPTH];
    logic [PROB_WIDTH-1:0] rd_data_reg;

    // Write one entry per load item
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read on character items only, hold otherwise
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bmg_accum.sv =====
// Running sum and transition count, with a result register per finished string.
`include "bigram_markov_gibberish_scorer_macros.svh"

module bmg_accum #(
    parameter int PROB_WIDTH  = 16,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 take,
    input  bmg_pkg::s1_ctrl_t                    take_ctrl,
    output logic                                 ready,
    input  logic [PROB_WIDTH-1:0]                entry,
    output logic                                 res_valid,
    output logic signed [bmg_pkg::SUM_WIDTH-1:0] res_sum,
    output logic [COUNT_WIDTH-1:0]               res_count,
    input  logic                                 res_ready
);

    localparam int SW = bmg_pkg::SUM_WIDTH;

    logic                  v1_reg, v1_next;
    bmg_pkg::s1_ctrl_t     ctrl_reg;
    logic signed [SW-1:0]  sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                  res_valid_reg, res_valid_next;
    logic signed [SW-1:0]  res_sum_reg;
    logic [COUNT_WIDTH-1:0] res_count_reg;

    logic                  go1;
    logic                  res_adv;
    logic signed [SW:0]    entry_ext;
    logic signed [SW:0]    sum_wide;
    logic signed [SW-1:0]  sum_sat;
    logic [COUNT_WIDTH-1:0] count_sat;

    // Stage moves on unless a finished string finds the result register full
    assign res_adv = !res_valid_reg || res_ready;
    assign go1     = v1_reg && (!ctrl_reg.last || res_adv);
    assign ready   = !v1_reg || go1;

    // Add the entry and clamp to the signed sum range
    always_comb begin
        entry_ext = ctrl_reg.add ? (SW + 1)'(signed'(entry)) : '0;
        sum_wide  = {sum_reg[SW-1], sum_reg} + entry_ext;
        if (sum_wide[SW] != sum_wide[SW-1]) begin
            sum_sat = {sum_wide[SW], {(SW - 1){~sum_wide[SW]}}};
        end else begin
            sum_sat = sum_wide[SW-1:0];
        end
        if (ctrl_reg.add && count_reg != '1) begin
            count_sat = count_reg + COUNT_WIDTH'(1);
        end else begin
            count_sat = count_reg;
        end
    end

    // Next state of the stage, the accumulator and the result register
    always_comb begin
        v1_next        = v1_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg;
        if (go1) begin
            v1_next = 1'b0;
            if (ctrl_reg.last) begin
                sum_next   = '0;
                count_next = '0;
            end else begin
                sum_next   = sum_sat;
                count_next = count_sat;
            end
        end
        if (take) begin
            v1_next = 1'b1;
        end
        if (go1 && ctrl_reg.last) begin
            res_valid_next = 1'b1;
        end else if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            ctrl_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            v1_reg        <= v1_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (take) begin
                ctrl_reg <= take_ctrl;
            end
        end
    end

    // Capture a finished string
    always_ff @(posedge aclk) begin
        if (go1 && ctrl_reg.last) begin
            res_sum_reg   <= sum_sat;
            res_count_reg <= count_sat;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_sum   = res_sum_reg;
    assign res_count = res_count_reg;

    `BMG_ASSERT_NEXT(a_accum_hold, v1_reg && !go1,
        $stable(sum_reg) && $stable(count_reg), "accumulator changed while stalled")
    `BMG_ASSERT_NEXT(a_res_hold, res_valid_reg && !res_ready,
        res_valid_reg && $stable(res_sum_reg) && $stable(res_count_reg),
        "blocked string result was lost or changed")

endmodule

// ===== hw/rtl/bmg_judge.sv =====
// Threshold scaling by the count, compare and output register.
`include "bigram_markov_gibberish_scorer_macros.svh"

module bmg_judge #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [bmg_pkg::THR_WIDTH-1:0] log_threshold,
    input  logic                                 in_valid,
    input  logic signed [bmg_pkg::SUM_WIDTH-1:0] in_sum,
    input  logic [COUNT_WIDTH-1:0]               in_count,
    output logic                                 in_ready,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_is_gibberish,
    output logic signed [bmg_pkg::SUM_WIDTH-1:0] m_log_sum,
    output logic [COUNT_WIDTH-1:0]               m_transition_count
);

    localparam int SW         = bmg_pkg::SUM_WIDTH;
    localparam int PROD_WIDTH = COUNT_WIDTH + bmg_pkg::THR_WIDTH + 1;
    localparam int CMP_WIDTH  = (PROD_WIDTH > SW) ? PROD_WIDTH : SW;

    logic                          va_reg, va_next;
    logic signed [PROD_WIDTH-1:0]  prod_reg;
    logic signed [SW-1:0]          sum_a_reg;
    logic [COUNT_WIDTH-1:0]        count_a_reg;
    logic                          m_valid_reg, m_valid_next;
    logic                          gib_reg;
    logic signed [SW-1:0]          sum_o_reg;
    logic [COUNT_WIDTH-1:0]        count_o_reg;

    logic                          out_adv;
    logic                          a_adv;
    logic                          in_fire;
    logic                          a_fire;
    logic [COUNT_WIDTH-1:0]        cnt_eff;
    logic signed [PROD_WIDTH-1:0]  prod_next;
    logic                          gib_next;

    assign out_adv  = !m_valid_reg || m_ready;
    assign a_adv    = !va_reg || out_adv;
    assign in_ready = a_adv;
    assign in_fire  = in_valid && a_adv;
    assign a_fire   = va_reg && out_adv;

    // Scale the threshold by the count, an empty string counts as one
    assign cnt_eff   = (in_count == '0) ? COUNT_WIDTH'(1) : in_count;
    assign prod_next = PROD_WIDTH'(signed'({1'b0, cnt_eff})) * PROD_WIDTH'(log_threshold);

    // Flag when the sum is at or below the scaled threshold
    assign gib_next = CMP_WIDTH'(sum_a_reg) <= CMP_WIDTH'(prod_reg);

    always_comb begin
        va_next = va_reg;
        if (in_fire) begin
            va_next = 1'b1;
        end else if (a_fire) begin
            va_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (a_fire) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            va_reg      <= va_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Product stage payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            prod_reg    <= prod_next;
            sum_a_reg   <= in_sum;
            count_a_reg <= in_count;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (a_fire) begin
            gib_reg     <= gib_next;
            sum_o_reg   <= sum_a_reg;
            count_o_reg <= count_a_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_is_gibberish     = gib_reg;
    assign m_log_sum          = sum_o_reg;
    assign m_transition_count = count_o_reg;

    `BMG_ASSERT_NEXT(a_judge_drain, va_reg && out_adv, m_valid_reg,
        "product stage did not move into the output register")

endmodule

// ===== hw/rtl/bigram_markov_gibberish_scorer.sv =====
// Top level of the bigram gibberish scorer: byte decode, table, accumulator, judge.
//
//  channel   ports                       direction  moves
//  -------   -------------------------   ---------  -------------------------------
//  input     s_valid / s_ready / s_*     in         load item or string byte item
//  result    m_valid / m_ready / m_*     out        one score item per string
//  config    log_threshold_we / _wdata   in         threshold write, no wait
//
//  One item per cycle while the input is not stalled; the table read and the sum add set this rate.
//  A score item passes the accumulator stage, the result register, the product
//  stage and the output register once the last byte of its string is accepted.
//  Reset clears the string state and loads the default threshold; the table is
//  not cleared and must be loaded before it is read. The input stalls only while
//  a finished string waits in the accumulator behind a full scoring pipeline.
`include "bigram_markov_gibberish_scorer_macros.svh"

module bigram_markov_gibberish_scorer #(
    parameter int PROB_WIDTH  = 16,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 log_threshold_we,
    input  logic signed [bmg_pkg::THR_WIDTH-1:0] log_threshold_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_command,
    input  logic [bmg_pkg::CHAR_WIDTH-1:0]       s_char_code,
    input  logic                                 s_last,
    input  logic [bmg_pkg::IDX_WIDTH-1:0]        s_entry_row,
    input  logic [bmg_pkg::IDX_WIDTH-1:0]        s_entry_col,
    input  logic signed [bmg_pkg::LOAD_WIDTH-1:0] s_entry_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_is_gibberish,
    output logic signed [bmg_pkg::SUM_WIDTH-1:0] m_log_sum,
    output logic [COUNT_WIDTH-1:0]               m_transition_count
);

    localparam int IW = bmg_pkg::IDX_WIDTH;

    logic signed [bmg_pkg::THR_WIDTH-1:0] thr_reg;
    logic [IW-1:0]                        prev_index_reg, prev_index_next;
    logic                                 have_prev_reg, have_prev_next;

    logic                                 accept;
    logic                                 is_char;
    logic                                 take;
    bmg_pkg::char_info_t                  info;
    bmg_pkg::s1_ctrl_t                    take_ctrl;
    logic                                 load_ok;
    logic signed [31:0]                   load_ext;
    logic                                 wr_en;
    logic [bmg_pkg::ADDR_WIDTH-1:0]       wr_addr;
    logic [PROB_WIDTH-1:0]                wr_data;
    logic [bmg_pkg::ADDR_WIDTH-1:0]       rd_addr;
    logic [PROB_WIDTH-1:0]                rd_data;
    logic                                 accum_ready;
    logic                                 res_valid;
    logic signed [bmg_pkg::SUM_WIDTH-1:0] res_sum;
    logic [COUNT_WIDTH-1:0]               res_count;
    logic                                 res_ready;

    assign s_ready = accum_ready;
    assign accept  = s_valid && s_ready;
    assign is_char = (s_command == bmg_pkg::CMD_CHAR);
    assign take    = accept && is_char;
    assign info    = bmg_pkg::char_decode(s_char_code);

    // Load path: drop out-of-range entries, wrap the value to the table width
    assign load_ok  = (s_entry_row < IW'(bmg_pkg::ALPHABET_SIZE))
                   && (s_entry_col < IW'(bmg_pkg::ALPHABET_SIZE));
    assign load_ext = 32'(s_entry_value);
    assign wr_en    = accept && (s_command == bmg_pkg::CMD_LOAD) && load_ok;
    assign wr_addr  = bmg_pkg::table_addr(s_entry_row, s_entry_col);
    assign wr_data  = load_ext[PROB_WIDTH-1:0];

    // Character path: look up the bigram of the previous and this character
    assign rd_addr        = bmg_pkg::table_addr(prev_index_reg, info.idx);
    assign take_ctrl.add  = info.kept && have_prev_reg;
    assign take_ctrl.last = s_last;

    // Track the previous kept character; clear at the end of a string
    always_comb begin
        prev_index_next = prev_index_reg;
        have_prev_next  = have_prev_reg;
        if (take) begin
            if (s_last) begin
                prev_index_next = '0;
                have_prev_next  = 1'b0;
            end else if (info.kept) begin
                prev_index_next = info.idx;
                have_prev_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_index_reg <= '0;
            have_prev_reg  <= 1'b0;
            thr_reg        <= bmg_pkg::THR_RESET;
        end else begin
            prev_index_reg <= prev_index_next;
            have_prev_reg  <= have_prev_next;
            if (log_threshold_we) begin
                thr_reg <= log_threshold_wdata;
            end
        end
    end

    bmg_table #(
        .PROB_WIDTH(PROB_WIDTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (take),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bmg_accum #(
        .PROB_WIDTH (PROB_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .take_ctrl(take_ctrl),
        .ready    (accum_ready),
        .entry    (rd_data),
        .res_valid(res_valid),
        .res_sum  (res_sum),
        .res_count(res_count),
        .res_ready(res_ready)
    );

    bmg_judge #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_judge (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .log_threshold     (thr_reg),
        .in_valid          (res_valid),
        .in_sum            (res_sum),
        .in_count          (res_count),
        .in_ready          (res_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_is_gibberish    (m_is_gibberish),
        .m_log_sum         (m_log_sum),
        .m_transition_count(m_transition_count)
    );

    `BMG_ASSERT_NEXT(a_string_end_clears, take && s_last,
        !have_prev_reg && prev_index_reg == '0, "string state not cleared after last byte")

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the bigram gibberish scorer: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int PROB_W       = 16;
    localparam int COUNT_W      = 24;
    localparam int SUM_W        = bmg_pkg::SUM_WIDTH;
    localparam int THR_W        = bmg_pkg::THR_WIDTH;
    localparam int CHAR_W       = bmg_pkg::CHAR_WIDTH;
    localparam int IDX_W        = bmg_pkg::IDX_WIDTH;
    localparam int LOAD_W       = bmg_pkg::LOAD_WIDTH;
    localparam int ALPHA        = bmg_pkg::ALPHABET_SIZE;
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_CYCLES = 400000;
    localparam longint SUM_HI    = (64'sd1 <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO    = -(64'sd1 <<< (SUM_W - 1));
    localparam longint COUNT_TOP = (64'sd1 <<< COUNT_W) - 1;

    typedef struct packed {
        logic                    gib;
        logic signed [SUM_W-1:0] sum;
        logic [COUNT_W-1:0]      count;
    } score_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     log_threshold_we = 1'b0;
    logic signed [THR_W-1:0]  log_threshold_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_command = bmg_pkg::CMD_CHAR;
    logic [CHAR_W-1:0]        s_char_code = '0;
    logic                     s_last = 1'b0;
    logic [IDX_W-1:0]         s_entry_row = '0;
    logic [IDX_W-1:0]         s_entry_col = '0;
    logic signed [LOAD_W-1:0] s_entry_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_is_gibberish;
    logic signed [SUM_W-1:0]  m_log_sum;
    logic [COUNT_W-1:0]       m_transition_count;

    // Predictor state
    logic signed [PROB_W-1:0] bigram_table [0:bmg_pkg::TABLE_DEPTH-1];
    int                       prev_idx = 0;
    bit                       have_prev = 1'b0;
    longint                   run_sum = 0;
    longint                   run_count = 0;
    logic signed [THR_W-1:0]  threshold = bmg_pkg::THR_RESET;
    score_t                   score_q [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int fail_count  = 0;
    int cycle_count = 0;

    bigram_markov_gibberish_scorer #(
        .PROB_WIDTH (PROB_W),
        .COUNT_WIDTH(COUNT_W)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .log_threshold_we   (log_threshold_we),
        .log_threshold_wdata(log_threshold_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_char_code        (s_char_code),
        .s_last             (s_last),
        .s_entry_row        (s_entry_row),
        .s_entry_col        (s_entry_col),
        .s_entry_value      (s_entry_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_is_gibberish     (m_is_gibberish),
        .m_log_sum          (m_log_sum),
        .m_transition_count (m_transition_count)
    );

    always #1 aclk = ~aclk;

    // Alphabet index of a byte, or -1 when the byte is dropped
    function automatic int fold_index(input logic [CHAR_W-1:0] c);
        if (c >= bmg_pkg::LOWER_A && c <= bmg_pkg::LOWER_Z)
            return int'(c) - int'(bmg_pkg::LOWER_A);
        if (c >= bmg_pkg::UPPER_A && c <= bmg_pkg::UPPER_Z)
            return int'(c) - int'(bmg_pkg::UPPER_A);
        if (c == bmg_pkg::SPACE_CHAR) return ALPHA - 1;
        return -1;
    endfunction

    // Advance the predicted string state by one accepted item
    function automatic void score_item(input logic cmd, input logic [CHAR_W-1:0] ch,
                                       input logic last, input logic [IDX_W-1:0] row,
                                       input logic [IDX_W-1:0] col,
                                       input logic signed [LOAD_W-1:0] val);
        int     ci;
        longint cnt;
        score_t sc;
        if (cmd == bmg_pkg::CMD_LOAD) begin
            if (row < ALPHA && col < ALPHA)
                bigram_table[int'(row) * ALPHA + int'(col)] = val;
            return;
        end
        ci = fold_index(ch);
        if (ci >= 0) begin
            if (have_prev) begin
                run_sum = run_sum + longint'(bigram_table[prev_idx * ALPHA + ci]);
                if (run_sum > SUM_HI) run_sum = SUM_HI;
                if (run_sum < SUM_LO) run_sum = SUM_LO;
                if (run_count < COUNT_TOP) run_count++;
            end
            prev_idx  = ci;
            have_prev = 1'b1;
        end
        if (last) begin
            cnt      = (run_count != 0) ? run_count : 1;
            sc.gib   = (run_sum <= cnt * longint'(threshold));
            sc.sum   = SUM_W'(run_sum);
            sc.count = COUNT_W'(run_count);
            score_q  = {score_q, sc};
            run_sum   = 0;
            run_count = 0;
            have_prev = 1'b0;
            prev_idx  = 0;
        end
    endfunction

    // Send one item, idling first at the current rate, and predict it once accepted
    task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch,
                             input logic last, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic signed [LOAD_W-1:0] val);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_command     <= cmd;
        s_char_code   <= ch;
        s_last        <= last;
        s_entry_row   <= row;
        s_entry_col   <= col;
        s_entry_value <= val;
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        score_item(cmd, ch, last, row, col, val);
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        send_item(bmg_pkg::CMD_CHAR, ch, last, IDX_W'($urandom), IDX_W'($urandom),
                  LOAD_W'($urandom));
    endtask

    task automatic send_load(input int row, input int col, input int val, input logic last);
        send_item(bmg_pkg::CMD_LOAD, CHAR_W'($urandom), last, IDX_W'(row), IDX_W'(col),
                  LOAD_W'(val));
    endtask

    // Send a string, the last flag on its final byte
    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == txt.len() - 1);
    endtask

    // Hold the sender until every expected score has come, then let the pipe settle
    task automatic wait_for_scores();
        s_valid <= 1'b0;
        while (score_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_threshold(input int val);
        wait_for_scores();
        log_threshold_we    <= 1'b1;
        log_threshold_wdata <= THR_W'(val);
        @(posedge aclk);
        log_threshold_we    <= 1'b0;
        threshold = THR_W'(val);
    endtask

    function automatic int pick_entry_value();
        if ($urandom_range(0, 3) != 0) return -int'($urandom_range(0, 8191));
        return -int'($urandom_range(0, 32768));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_kept_char();
        int idx;
        idx = $urandom_range(0, 25);
        if ($urandom_range(0, 99) < 13) return bmg_pkg::SPACE_CHAR;
        if ($urandom_range(0, 1) != 0) return bmg_pkg::UPPER_A + CHAR_W'(idx);
        return bmg_pkg::LOWER_A + CHAR_W'(idx);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_dropped_char();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom);
        while (fold_index(c) >= 0) c = CHAR_W'($urandom);
        return c;
    endfunction

    // Strings of at most one kept character, under the reset threshold
    task automatic test_short_strings();
        send_text("a");
        send_char(8'h2e, 1'b1);
        send_char(bmg_pkg::SPACE_CHAR, 1'b0);
        send_char(8'h7e, 1'b1);
    endtask

    // Fill the whole table, extremes at fixed places
    task automatic test_table_load();
        for (int r = 0; r < ALPHA; r++)
            for (int c = 0; c < ALPHA; c++)
                send_load(r, c, pick_entry_value(), 1'b0);
        send_load(0, 0, -32768, 1'b0);
        send_load(1, 1, 0, 1'b0);
        send_load(ALPHA - 1, ALPHA - 1, -1, 1'b0);
    endtask

    // Loads out of range are ignored; loads never end a string
    task automatic test_load_range();
        send_char(8'h62, 1'b0);
        send_load(ALPHA, 0, 0, 1'b1);
        send_load(0, 31, 0, 1'b1);
        send_load(31, 31, -32768, 1'b0);
        send_char(8'h65, 1'b1);
        send_text("b a  ");
    endtask

    // Case folding, boundary bytes around the letters, dropped byte carrying last
    task automatic test_fold_and_drop();
        send_char(8'h41, 1'b0);
        send_char(8'h40, 1'b0);
        send_char(8'h7a, 1'b0);
        send_char(8'h5b, 1'b0);
        send_char(8'h60, 1'b0);
        send_char(8'h5a, 1'b0);
        send_char(8'h7b, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'hff, 1'b1);
    endtask

    // Threshold at its minimum and at zero, equality hitting the flag
    task automatic test_threshold_extremes();
        set_threshold(-32768);
        send_text("aAa");
        send_text("bb");
        set_threshold(0);
        send_text("bb");
        send_text("q");
        send_text("Zz z");
    endtask

    // Mostly well-formed strings with random content, some loads and noise
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int thr,
                                       input int n_items);
        int  sent;
        int  len;
        int  kind;
        int  row;
        int  col;
        bit  paused;
        logic [CHAR_W-1:0] ch;
        sent   = 0;
        paused = 1'b0;
        set_threshold(thr);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (!paused && sent >= n_items / 2) begin
                paused = 1'b1;
                wait_for_scores();
            end
            if (kind < 82) begin
                len = ($urandom_range(0, 99) < 4) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 99) < 12) ch = pick_dropped_char();
                    else ch = pick_kept_char();
                    sent++;
                    send_char(ch, i == len - 1);
                end
            end else if (kind < 94) begin
                if ($urandom_range(0, 99) < 80) begin
                    row = $urandom_range(0, ALPHA - 1);
                    col = $urandom_range(0, ALPHA - 1);
                end else begin
                    row = $urandom_range(0, 31);
                    col = $urandom_range(0, 31);
                end
                sent++;
                send_load(row, col, pick_entry_value(), 1'($urandom_range(0, 1)));
            end else begin
                ch = CHAR_W'($urandom);
                sent++;
                send_char(ch, 1'($urandom_range(0, 1)));
            end
        end
        // close any open string
        send_char(CHAR_W'($urandom), 1'b1);
    endtask

    // Receiver stalls at the current rate
    always @(posedge aclk)
        m_ready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);

    // Compare each accepted score with the oldest prediction
    always @(posedge aclk) begin
        score_t want;
        if (aresetn && m_valid && m_ready) begin
            if (score_q.size() == 0) begin
                $display("%0t: unexpected score, expected none, actual gib=%0b sum=%0d count=%0d",
                         $time, m_is_gibberish, m_log_sum, m_transition_count);
                fail_count++;
            end else begin
                want = score_q.pop_front();
                if (m_is_gibberish !== want.gib) begin
                    $display("%0t: is_gibberish mismatch, expected %0b, actual %0b",
                             $time, want.gib, m_is_gibberish);
                    fail_count++;
                end
                if (m_log_sum !== want.sum) begin
                    $display("%0t: log_sum mismatch, expected %0d, actual %0d",
                             $time, $signed(want.sum), m_log_sum);
                    fail_count++;
                end
                if (m_transition_count !== want.count) begin
                    $display("%0t: transition_count mismatch, expected %0d, actual %0d",
                             $time, want.count, m_transition_count);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_short_strings();
        test_table_load();
        test_load_range();
        test_fold_and_drop();
        test_threshold_extremes();
        test_random_traffic(31, 78, -int'($urandom_range(1024, 8192)), 410);
        test_random_traffic(78, 31, -int'($urandom_range(0, 32768)), 410);
        test_random_traffic(0, 0, -4096, 410);

        wait_for_scores();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
